// ===== hdl/diff_drive_radius_turn_macros.svh =====
// Assertion macros shared by the checker of the radius turn block.
`ifndef DIFF_DRIVE_RADIUS_TURN_MACROS_SVH
`define DIFF_DRIVE_RADIUS_TURN_MACROS_SVH
// General concurrent check on clk, quiet during reset
`define DDRT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Same-cycle implication
`define DDRT_IMPLY(lbl, a, b, msg) \
	`DDRT_ASSERT(lbl, (a) |-> (b), msg)
// Next-cycle implication
`define DDRT_NEXT(lbl, a, b, msg) \
	`DDRT_ASSERT(lbl, (a) |=> (b), msg)
`endif

// ===== hdl/ddrt_pkg.sv =====
//------------------------------------------------------------------------------
// ddrt_pkg
// Types and constants of the differential drive radius turn block.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package ddrt_pkg;
	localparam int MaxSafeRpmDef = 1000;
	localparam int NW = 49;   // divider numerator width
	localparam int DW = 36;   // divider denominator width
	localparam int QW = 12;   // quotient width, covers a limit up to 4095
	localparam logic [9:0] PERMILLE_FULL = 10'd1000;

	// register indexes
	localparam logic [1:0] REG_TRACK  = 2'd0;
	localparam logic [1:0] REG_MAXRPM = 2'd1;
	localparam logic [1:0] REG_MINRPM = 2'd2;
	localparam logic [1:0] REG_STRICT = 2'd3;

	typedef struct packed {
		logic [9:0]  track_width_mm;
		logic [11:0] max_wheel_rpm;
		logic [11:0] min_rpm;
		logic        strict_unscaled;
	} cfg_t;

	// divide job from front to back
	typedef struct packed {
		logic [NW-1:0] n_l;
		logic [NW-1:0] n_r;
		logic [NW-1:0] n_p;
		logic [DW-1:0] d;
		logic          sgn_l;
		logic          sgn_r;
		logic          scaled;
		logic          rej;
	} job_t;

	typedef struct packed {
		logic signed [12:0] left_rpm;
		logic signed [12:0] right_rpm;
		logic [9:0]         scale_permille;
		logic               ok;
	} res_t;
endpackage

// ===== hdl/ddrt_fifo.sv =====
//------------------------------------------------------------------------------
// ddrt_fifo
// Small register queue with full and empty flags.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module ddrt_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic         pop,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout,
	output logic         full,
	output logic         empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rp_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (do_pop)  rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wp_q] <= din;
	end
endmodule

// ===== hdl/ddrt_front.sv =====
//------------------------------------------------------------------------------
// ddrt_front
// Four-stage front: wheel numerators, peak, limit checks and divide operands.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module ddrt_front #(
	parameter int MAX_SAFE_RPM = ddrt_pkg::MaxSafeRpmDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ddrt_pkg::cfg_t      cfg,
	input  logic                push,
	output logic                full,
	input  logic signed [20:0]  radius_mm,
	input  logic signed [12:0]  center_rpm,
	output logic                job_push,
	input  logic                job_full,
	output ddrt_pkg::job_t      job
);
	import ddrt_pkg::*;

	localparam logic [11:0] MaxSafe = 12'(MAX_SAFE_RPM);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4;

	// stage 1 registers
	logic signed [20:0] r_s1;
	logic signed [12:0] c_s1;

	// stage 2
	logic signed [21:0] d2;
	logic signed [22:0] dm, dp;
	logic signed [35:0] nl_c, nr_c;
	logic [21:0]        ad_c;
	logic [11:0]        lim_c;
	logic [33:0]        lad_c;
	logic               rej_c;
	logic signed [35:0] nl_s2, nr_s2;
	logic [21:0]        ad_s2;
	logic [11:0]        lim_s2;
	logic [33:0]        lad_s2;
	logic               neg_s2, rej_s2;

	// stage 3
	logic signed [35:0] nlf, nrf;
	logic [34:0]        ml_c, mr_c, pk_c;
	logic [34:0]        ml_s3, mr_s3, pk_s3;
	logic               sl_s3, sr_s3, sc_s3, rej_s3;
	logic [21:0]        ad_s3;
	logic [11:0]        lim_s3;
	logic [33:0]        lad_s3;

	// stage 4
	logic [46:0] pl_c, pr_c;
	job_t        job_c, job_s4;

	// whole pipeline moves unless the last stage is blocked
	assign en       = !(v_s4 && job_full);
	assign full     = !en;
	assign job_push = v_s4;
	assign job      = job_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// stage 1: capture transfer
	always_ff @(posedge clk) begin
		if (en) begin
			r_s1 <= radius_mm;
			c_s1 <= center_rpm;
		end
	end

	// stage 2: numerators c*(2R-W), c*(2R+W), |2R| and limit checks
	always_comb begin
		d2    = {r_s1, 1'b0};
		dm    = $signed({d2[21], d2}) - $signed({13'b0, cfg.track_width_mm});
		dp    = $signed({d2[21], d2}) + $signed({13'b0, cfg.track_width_mm});
		nl_c  = c_s1 * dm;
		nr_c  = c_s1 * dp;
		ad_c  = d2[21] ? 22'(-d2) : 22'(d2);
		lim_c = cfg.strict_unscaled ? MaxSafe : cfg.max_wheel_rpm;
		lad_c = 34'(lim_c) * 34'(ad_c);
		rej_c = (r_s1 == '0) || (cfg.track_width_mm == '0) ||
			(lim_c < cfg.min_rpm) || (lim_c > MaxSafe);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nl_s2  <= nl_c;
			nr_s2  <= nr_c;
			ad_s2  <= ad_c;
			lim_s2 <= lim_c;
			lad_s2 <= lad_c;
			neg_s2 <= d2[21];
			rej_s2 <= rej_c;
		end
	end

	// stage 3: fold sign of 2R, magnitudes, peak and scaling decision
	always_comb begin
		nlf  = neg_s2 ? -nl_s2 : nl_s2;
		nrf  = neg_s2 ? -nr_s2 : nr_s2;
		ml_c = nlf[35] ? 35'(-nlf) : 35'(nlf);
		mr_c = nrf[35] ? 35'(-nrf) : 35'(nrf);
		pk_c = (ml_c > mr_c) ? ml_c : mr_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ml_s3  <= ml_c;
			mr_s3  <= mr_c;
			pk_s3  <= pk_c;
			sl_s3  <= nlf[35];
			sr_s3  <= nrf[35];
			sc_s3  <= pk_c > 35'(lad_s2);
			rej_s3 <= rej_s2 || ((pk_c > 35'(lad_s2)) && cfg.strict_unscaled);
			ad_s3  <= ad_s2;
			lim_s3 <= lim_s2;
			lad_s3 <= lad_s2;
		end
	end

	// stage 4: rounded divide operands (2n + d) / (2d)
	always_comb begin
		pl_c         = 47'(lim_s3) * 47'(ml_s3);
		pr_c         = 47'(lim_s3) * 47'(mr_s3);
		job_c.n_l    = sc_s3 ? ({1'b0, pl_c, 1'b0} + NW'(pk_s3))
			: (NW'({ml_s3, 1'b0}) + NW'(ad_s3));
		job_c.n_r    = sc_s3 ? ({1'b0, pr_c, 1'b0} + NW'(pk_s3))
			: (NW'({mr_s3, 1'b0}) + NW'(ad_s3));
		job_c.n_p    = NW'(lad_s3) * NW'(2000) + NW'(pk_s3);
		job_c.d      = sc_s3 ? {pk_s3, 1'b0} : DW'({ad_s3, 1'b0});
		job_c.sgn_l  = sl_s3;
		job_c.sgn_r  = sr_s3;
		job_c.scaled = sc_s3;
		job_c.rej    = rej_s3;
	end

	always_ff @(posedge clk) begin
		if (en) job_s4 <= job_c;
	end
endmodule

// ===== hdl/ddrt_back.sv =====
//------------------------------------------------------------------------------
// ddrt_back
// Three-lane restoring divider, speed floor check and result packing.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module ddrt_back (
	input  logic           clk,
	input  logic           arst_n,
	input  ddrt_pkg::cfg_t cfg,
	input  logic           job_empty,
	output logic           job_pop,
	input  ddrt_pkg::job_t job,
	input  logic           res_full,
	output logic           res_push,
	output ddrt_pkg::res_t res
);
	import ddrt_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_OUT  = 2'd2;
	localparam logic [3:0] KTop    = 4'(QW - 1);

	logic [1:0]    state_q;
	logic [3:0]    k_q;
	logic [NW-1:0] rl_q, rr_q, rp_q;
	logic [QW-1:0] ql_q, qr_q, qp_q;
	logic [DW-1:0] d_q;
	logic          sl_q, sr_q, sc_q, rej_q;
	logic [NW-1:0] dsh;
	logic          gl, gr, gp;
	logic          slow;

	assign job_pop  = (state_q == ST_IDLE) && !job_empty;
	assign res_push = (state_q == ST_OUT) && !res_full;

	// shifted divisor and per-lane compare
	assign dsh = NW'(d_q) << k_q;
	assign gl  = rl_q >= dsh;
	assign gr  = rr_q >= dsh;
	assign gp  = rp_q >= dsh;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!job_empty) begin
						k_q     <= KTop;
						state_q <= job.rej ? ST_OUT : ST_DIV;
					end
				end
				ST_DIV: begin
					if (k_q == '0) state_q <= ST_OUT;
					else k_q <= k_q - 1'b1;
				end
				ST_OUT: begin
					if (!res_full) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// divider lanes
	always_ff @(posedge clk) begin
		if (job_pop) begin
			rl_q  <= job.n_l;
			rr_q  <= job.n_r;
			rp_q  <= job.n_p;
			d_q   <= job.d;
			sl_q  <= job.sgn_l;
			sr_q  <= job.sgn_r;
			sc_q  <= job.scaled;
			rej_q <= job.rej;
			ql_q  <= '0;
			qr_q  <= '0;
			qp_q  <= '0;
		end else if (state_q == ST_DIV) begin
			if (gl) begin
				rl_q       <= rl_q - dsh;
				ql_q[k_q]  <= 1'b1;
			end
			if (gr) begin
				rr_q       <= rr_q - dsh;
				qr_q[k_q]  <= 1'b1;
			end
			if (gp) begin
				rp_q       <= rp_q - dsh;
				qp_q[k_q]  <= 1'b1;
			end
		end
	end

	// result: sign, floor check, zeros on rejection
	always_comb begin
		slow = ((ql_q != '0) && (12'(ql_q) < cfg.min_rpm)) ||
			((qr_q != '0) && (12'(qr_q) < cfg.min_rpm));
		res.ok = !rej_q && !slow;
		if (res.ok) begin
			res.left_rpm       = sl_q ? -$signed(13'(ql_q)) : $signed(13'(ql_q));
			res.right_rpm      = sr_q ? -$signed(13'(qr_q)) : $signed(13'(qr_q));
			res.scale_permille = sc_q ? 10'(qp_q) : PERMILLE_FULL;
		end else begin
			res.left_rpm       = '0;
			res.right_rpm      = '0;
			res.scale_permille = '0;
		end
	end
endmodule

// ===== hdl/diff_drive_radius_turn.sv =====
// Differential drive radius turn: one result per command. A command enters the
// four-stage front (back to back while the job queue has room); the back's
// three-lane divider then loads the job, finds the 12 quotient bits one after
// another and holds the result until the result queue takes it, and it takes
// no new command before then. Rejected commands skip the divide and return
// zeros with ok low.
//------------------------------------------------------------------------------
// diff_drive_radius_turn
// Top level: APB registers, front pipeline, job queue, divider, result queue.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module diff_drive_radius_turn #(
	parameter int MAX_SAFE_RPM = ddrt_pkg::MaxSafeRpmDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               push,
	output logic               full,
	input  logic signed [20:0] radius_mm,
	input  logic signed [12:0] center_rpm,
	output logic               empty,
	input  logic               pop,
	output logic signed [12:0] left_rpm,
	output logic signed [12:0] right_rpm,
	output logic [9:0]         scale_permille,
	output logic               ok
);
	import ddrt_pkg::*;

	cfg_t cfg_q;
	job_t job_in, job_out;
	res_t res_in, res_out;
	logic job_push, job_full, job_empty, job_pop;
	logic res_push, res_full;
	logic wr;

	// configuration registers
	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.track_width_mm  <= 10'd201;
			cfg_q.max_wheel_rpm   <= 12'd1000;
			cfg_q.min_rpm         <= 12'd10;
			cfg_q.strict_unscaled <= 1'b0;
		end else if (wr) begin
			case (paddr[3:2])
				REG_TRACK:  cfg_q.track_width_mm  <= pwdata[9:0];
				REG_MAXRPM: cfg_q.max_wheel_rpm   <= pwdata[11:0];
				REG_MINRPM: cfg_q.min_rpm         <= pwdata[11:0];
				REG_STRICT: cfg_q.strict_unscaled <= pwdata[0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (paddr[3:2])
			REG_TRACK:  prdata = {22'b0, cfg_q.track_width_mm};
			REG_MAXRPM: prdata = {20'b0, cfg_q.max_wheel_rpm};
			REG_MINRPM: prdata = {20'b0, cfg_q.min_rpm};
			REG_STRICT: prdata = {31'b0, cfg_q.strict_unscaled};
			default:    prdata = '0;
		endcase
	end

	ddrt_front #(.MAX_SAFE_RPM(MAX_SAFE_RPM)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.push       (push),
		.full       (full),
		.radius_mm  (radius_mm),
		.center_rpm (center_rpm),
		.job_push   (job_push),
		.job_full   (job_full),
		.job        (job_in)
	);

	ddrt_fifo #(.W($bits(job_t)), .DEPTH(2)) u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.pop    (job_pop),
		.din    (job_in),
		.dout   (job_out),
		.full   (job_full),
		.empty  (job_empty)
	);

	ddrt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_empty (job_empty),
		.job_pop   (job_pop),
		.job       (job_out),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	ddrt_fifo #(.W($bits(res_t)), .DEPTH(2)) u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.pop    (pop),
		.din    (res_in),
		.dout   (res_out),
		.full   (res_full),
		.empty  (empty)
	);

	assign left_rpm       = res_out.left_rpm;
	assign right_rpm      = res_out.right_rpm;
	assign scale_permille = res_out.scale_permille;
	assign ok             = res_out.ok;
endmodule

// ===== hdl/ddrt_checker.sv =====
//------------------------------------------------------------------------------
// ddrt_checker
// Port-level checks of the radius turn block, bound to the top level.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "diff_drive_radius_turn_macros.svh"
module ddrt_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               pready,
	input logic               empty,
	input logic               pop,
	input logic signed [12:0] left_rpm,
	input logic signed [12:0] right_rpm,
	input logic [9:0]         scale_permille,
	input logic               ok
);
	// rejected result carries zero speeds and scale
	`DDRT_IMPLY(a_rej_zero, !empty && !ok, left_rpm == 0 && right_rpm == 0 && scale_permille == 0, "rejected result not zero")
	// accepted result has a scale of at most full speed
	`DDRT_IMPLY(a_scale_max, !empty && ok, scale_permille <= 10'd1000, "scale out of range")
	// waiting result holds while not taken
	`DDRT_NEXT(a_hold, !empty && !pop, !empty && $stable(left_rpm) && $stable(right_rpm) && $stable(ok), "result changed while waiting")
	// register port never stalls
	`DDRT_ASSERT(a_pready, pready, "pready low")
endmodule

bind diff_drive_radius_turn ddrt_checker u_chk (.*);

// ===== bench/diff_drive_radius_turn_check.sv =====
//------------------------------------------------------------------------------
// diff_drive_radius_turn_check
// Checker for the radius turn block. It follows the register writes, works out
// the wheel speeds for every accepted command and compares them field by field
// with each result that is popped.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module diff_drive_radius_turn_check
	import ddrt_pkg::*;
#(
	parameter int MAX_SAFE_RPM = MaxSafeRpmDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	input  logic               push,
	input  logic               full,
	input  logic signed [20:0] radius_mm,
	input  logic signed [12:0] center_rpm,
	input  logic               empty,
	input  logic               pop,
	input  logic signed [12:0] left_rpm,
	input  logic signed [12:0] right_rpm,
	input  logic [9:0]         scale_permille,
	input  logic               ok,
	output int                 errors,
	output int                 pending
);
	cfg_t cfg;
	res_t speeds_due[$];

	function automatic longint absval(longint v);
		return v < 0 ? -v : v;
	endfunction

	// nearest integer, halves away from zero
	function automatic longint round_div(longint n, longint d);
		longint q;
		q = (2 * absval(n) + d) / (2 * d);
		return n < 0 ? -q : q;
	endfunction

	function automatic logic below_min(longint v);
		return v != 0 && absval(v) < longint'(cfg.min_rpm);
	endfunction

	function automatic res_t turn_speeds(logic signed [20:0] rad, logic signed [12:0] ctr);
		longint r, c, w, d, ad, nl, nr, peak, lim, lv, rv, pm;
		res_t o;
		o = '0;
		r = rad;
		c = ctr;
		w = cfg.track_width_mm;
		lim = cfg.strict_unscaled ? MAX_SAFE_RPM : cfg.max_wheel_rpm;
		if (r == 0 || w == 0 || lim < cfg.min_rpm || lim > MAX_SAFE_RPM)
			return o;
		d = 2 * r;
		ad = absval(d);
		// numerators carry the sign of d so that each wheel is n / |d|
		nl = c * (d - w);
		nr = c * (d + w);
		if (d < 0) begin
			nl = -nl;
			nr = -nr;
		end
		peak = absval(nl) > absval(nr) ? absval(nl) : absval(nr);
		pm = 1000;
		if (peak > lim * ad) begin
			if (cfg.strict_unscaled)
				return o;
			lv = round_div(lim * nl, peak);
			rv = round_div(lim * nr, peak);
			pm = (2000 * lim * ad + peak) / (2 * peak);
		end else begin
			lv = round_div(nl, ad);
			rv = round_div(nr, ad);
		end
		if (below_min(lv) || below_min(rv))
			return o;
		o.left_rpm = lv[12:0];
		o.right_rpm = rv[12:0];
		o.scale_permille = pm[9:0];
		o.ok = 1'b1;
		return o;
	endfunction

	assign pending = speeds_due.size();

	// register shadow
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.track_width_mm <= 10'd201;
			cfg.max_wheel_rpm <= 12'd1000;
			cfg.min_rpm <= 12'd10;
			cfg.strict_unscaled <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				REG_TRACK: cfg.track_width_mm <= pwdata[9:0];
				REG_MAXRPM: cfg.max_wheel_rpm <= pwdata[11:0];
				REG_MINRPM: cfg.min_rpm <= pwdata[11:0];
				REG_STRICT: cfg.strict_unscaled <= pwdata[0];
				default: ;
			endcase
		end
	end

	// predict on input transfer, compare on output transfer
	always @(posedge clk) begin
		res_t want;
		if (!arst_n) begin
			errors <= 0;
		end else begin
			if (push && !full)
				speeds_due.push_back(turn_speeds(radius_mm, center_rpm));
			if (pop && !empty) begin
				if (speeds_due.size() == 0) begin
					$display("%0t: unexpected result left %0d right %0d", $time,
						left_rpm, right_rpm);
					errors <= errors + 1;
				end else begin
					want = speeds_due.pop_front();
					if (want.left_rpm !== left_rpm || want.right_rpm !== right_rpm ||
							want.scale_permille !== scale_permille || want.ok !== ok) begin
						$display("%0t: expected left %0d right %0d scale %0d ok %0d", $time,
							want.left_rpm, want.right_rpm, want.scale_permille, want.ok);
						$display("%0t:   actual left %0d right %0d scale %0d ok %0d", $time,
							left_rpm, right_rpm, scale_permille, ok);
						errors <= errors + 1;
					end
				end
			end
		end
	end
endmodule

// ===== bench/diff_drive_radius_turn_test.sv =====
//------------------------------------------------------------------------------
// diff_drive_radius_turn_test
// Testbench top: drives register settings and turn commands with bursty input
// and a stalling receiver; the checker beside the block judges the results.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module diff_drive_radius_turn_test;
	import ddrt_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               push = 1'b0, full;
	logic signed [20:0] radius_mm = '0;
	logic signed [12:0] center_rpm = '0;
	logic               empty, pop = 1'b0;
	logic signed [12:0] left_rpm, right_rpm;
	logic [9:0]         scale_permille;
	logic               ok;
	logic               hold_go = 1'b0;
	int                 errors, pending;
	int                 burst_left = 0;

	always #5 clk = ~clk;

	diff_drive_radius_turn u_top (.*);

	diff_drive_radius_turn_check u_check (.*);

	// one command transfer; the block samples it at the accepting edge
	task automatic send_cmd(logic signed [20:0] r, logic signed [12:0] c);
		logic f;
		radius_mm <= r;
		center_rpm <= c;
		push <= 1'b1;
		do begin
			@(negedge clk);
			f = full;
			@(posedge clk);
		end while (f);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) :
				$urandom_range(0, 10);
			if ($urandom_range(0, 2) != 0) begin
				push <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	endtask

	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// let the block drain before touching registers or ending
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	function automatic logic signed [20:0] pick_radius();
		int k;
		k = $urandom_range(0, 99);
		if (k < 55)
			return 21'(($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(1, 3000)));
		if (k < 80)
			return 21'(($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(1, 100000)));
		if (k < 85)
			return 21'(($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(1, 4)));
		return 21'($urandom());
	endfunction

	function automatic logic signed [12:0] pick_center();
		if ($urandom_range(0, 9) < 7)
			return 13'(($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(0, 1500)));
		return 13'($urandom());
	endfunction

	// receiver: stalls on its own pattern, one long hold-off on request
	initial begin
		int mode;
		int run;
		bit held;
		@(posedge arst_n);
		forever begin
			if (hold_go && !held) begin
				held = 1'b1;
				pop <= 1'b0;
				repeat (400) @(posedge clk);
			end
			mode = $urandom_range(0, 3);
			run = $urandom_range(20, 200);
			repeat (run) begin
				case (mode)
					0: pop <= 1'b1;
					1: pop <= $urandom_range(0, 1);
					2: pop <= $urandom_range(0, 3) == 0;
					default: pop <= $urandom_range(0, 7) != 0;
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		logic [31:0] settings [7][4];
		settings = '{
			'{32'd201, 32'd1000, 32'd10, 32'd0},
			'{32'd1023, 32'd1000, 32'd1, 32'd0},
			'{32'd1, 32'd500, 32'd1, 32'd0},
			'{32'd300, 32'd200, 32'd50, 32'd1},
			'{32'd0, 32'd4095, 32'd4095, 32'd0},
			'{32'd60, 32'd1, 32'd1, 32'd0},
			'{32'd512, 32'd1000, 32'd1000, 32'd1}
		};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// directed: field extremes, scaling, slow wheels, pivots, zero radius
		send_cmd(21'sd0, 13'sd100);
		send_cmd(21'sd1, 13'sd4095);
		send_cmd(-21'sd1, 13'sh1000);
		send_cmd(21'sd1048575, 13'sd4095);
		send_cmd(21'sh100000, 13'sh1000);
		send_cmd(21'sd1048575, -13'sd1);
		send_cmd(21'sd100, 13'sd1);
		send_cmd(21'sd1000, 13'sd500);
		send_cmd(-21'sd1000, 13'sd500);
		send_cmd(21'sd100, 13'sd900);
		send_cmd(21'sd50, -13'sd3000);
		send_cmd(21'sd100, 13'sd0);
		send_cmd(21'sd101, 13'sd200);
		send_cmd(-21'sd100, -13'sd200);
		send_cmd(21'sd2, 13'sd7);
		send_cmd(21'sd5000, 13'sd10);
		send_cmd(21'sd5000, 13'sd9);
		send_cmd(21'sd3, 13'sd2000);
		drain();
		reg_write(REG_STRICT, 32'd1);
		send_cmd(21'sd50, 13'sd3000);
		send_cmd(21'sd1000, 13'sd500);
		drain();

		// random phases over the register settings
		for (int p = 0; p < 7; p++) begin
			reg_write(REG_TRACK, settings[p][0]);
			reg_write(REG_MAXRPM, settings[p][1]);
			reg_write(REG_MINRPM, settings[p][2]);
			reg_write(REG_STRICT, settings[p][3]);
			for (int i = 0; i < 270; i++) begin
				if (p == 1 && i == 40)
					hold_go <= 1'b1;
				send_cmd(pick_radius(), pick_center());
			end
			drain();
		end

		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
